// ===== design/vn4_pkg.sv =====
// ----------------------------------------------------------------------------
// vn4_pkg
// shared types and constants for the four-component vector normaliser
// ----------------------------------------------------------------------------
package vn4_pkg;

  // number of vector components
  localparam int unsigned LANES = 4;
  // width of every result word on the ports
  localparam int unsigned OUT_W = 32;
  // zero threshold register
  localparam int unsigned THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;
  // divider remainder width, divisor is at most 32 bits
  localparam int unsigned DRW = 34;

  // control that travels with a beat down the cell chain
  typedef struct packed {
    logic             vld;
    logic             is_zero;
    logic [LANES-1:0] neg;
  } vn4_ctl_t;

  // one finished result beat
  typedef struct packed {
    logic [LANES-1:0][OUT_W-1:0] norm;
    logic [OUT_W-1:0]            len;
    logic                        was_zero;
  } vn4_res_t;

endpackage

// ===== design/vn4_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vn4_sqrt_cell
// one digit of a pipelined restoring square root, one root bit per cell
// ----------------------------------------------------------------------------
module vn4_sqrt_cell #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  vn4_pkg::vn4_ctl_t                             ctl_i,
  input  logic [2*COMP_WIDTH+1:0]                       rad_i,
  input  logic [COMP_WIDTH+3:0]                         rem_i,
  input  logic [COMP_WIDTH:0]                           root_i,
  input  logic [vn4_pkg::LANES-1:0][COMP_WIDTH-1:0]     raw_i,
  output vn4_pkg::vn4_ctl_t                             ctl_o,
  output logic [2*COMP_WIDTH+1:0]                       rad_o,
  output logic [COMP_WIDTH+3:0]                         rem_o,
  output logic [COMP_WIDTH:0]                           root_o,
  output logic [vn4_pkg::LANES-1:0][COMP_WIDTH-1:0]     raw_o
);

  localparam int RADW = 2*COMP_WIDTH+2;
  localparam int RW   = COMP_WIDTH+4;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_i[RW-3:0], rad_i[RADW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[RADW-3:0], 2'b00};
      rem_o  <= ge ? (rem_sh - trial) : rem_sh;
      root_o <= {root_i[COMP_WIDTH-1:0], ge};
      raw_o  <= raw_i;
    end
  end

endmodule

// ===== design/vn4_div_cell.sv =====
// ----------------------------------------------------------------------------
// vn4_div_cell
// one quotient bit of a pipelined restoring divider, four lanes side by side
// ----------------------------------------------------------------------------
module vn4_div_cell #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   en_i,
  input  vn4_pkg::vn4_ctl_t                                      ctl_i,
  input  logic [vn4_pkg::OUT_W-1:0]                              len_i,
  input  logic [vn4_pkg::LANES-1:0][COMP_WIDTH-1:0]              raw_i,
  input  logic [vn4_pkg::LANES-1:0][vn4_pkg::DRW-1:0]            rem_i,
  input  logic [vn4_pkg::LANES-1:0][COMP_WIDTH+FRAC_BITS-1:0]    dvd_i,
  input  logic [vn4_pkg::LANES-1:0][COMP_WIDTH+FRAC_BITS-1:0]    quo_i,
  output vn4_pkg::vn4_ctl_t                                      ctl_o,
  output logic [vn4_pkg::OUT_W-1:0]                              len_o,
  output logic [vn4_pkg::LANES-1:0][COMP_WIDTH-1:0]              raw_o,
  output logic [vn4_pkg::LANES-1:0][vn4_pkg::DRW-1:0]            rem_o,
  output logic [vn4_pkg::LANES-1:0][COMP_WIDTH+FRAC_BITS-1:0]    dvd_o,
  output logic [vn4_pkg::LANES-1:0][COMP_WIDTH+FRAC_BITS-1:0]    quo_o
);

  localparam int DW  = COMP_WIDTH+FRAC_BITS;
  localparam int DRW = vn4_pkg::DRW;

  logic [vn4_pkg::LANES-1:0][DRW-1:0] r_sh;
  logic [vn4_pkg::LANES-1:0][DRW-1:0] r_nx;
  logic [vn4_pkg::LANES-1:0]          ge;
  logic [DRW-1:0]                     dsr;

  // shift in the next dividend bit and subtract where it fits
  always_comb begin
    dsr = DRW'(len_i);
    for (int i = 0; i < int'(vn4_pkg::LANES); i++) begin
      r_sh[i] = {rem_i[i][DRW-2:0], dvd_i[i][DW-1]};
      ge[i]   = (r_sh[i] >= dsr);
      r_nx[i] = ge[i] ? (r_sh[i] - dsr) : r_sh[i];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_o <= len_i;
      raw_o <= raw_i;
      for (int i = 0; i < int'(vn4_pkg::LANES); i++) begin
        rem_o[i] <= r_nx[i];
        dvd_o[i] <= {dvd_i[i][DW-2:0], 1'b0};
        quo_o[i] <= {quo_i[i][DW-2:0], ge[i]};
      end
    end
  end

endmodule

// ===== design/vector4_normalize.sv =====
// ----------------------------------------------------------------------------
// vector4_normalize
// normalises a signed fixed-point four-component vector to unit length
// ----------------------------------------------------------------------------
// Takes one vector per clock and returns one result per clock while the output
// buffer is not full. The pipeline is the front stages of magnitude, squaring
// and summing, COMP_WIDTH+1 square-root cells that each settle one root bit,
// a register for the length and zero check, COMP_WIDTH+FRAC_BITS divider cells
// that each settle one quotient bit in all four lanes, and the output register.
// The length of one subtract per cell sets the clock. A two-entry output buffer
// takes one more result while a result waits; in_ready_o drops only when both
// are full. Threshold writes are taken at once and should be made while idle.
module vector4_normalize #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] zero_threshold_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] comp_x_i,
  input  logic [31:0] comp_y_i,
  input  logic [31:0] comp_z_i,
  input  logic [31:0] comp_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] norm_x_o,
  output logic [31:0] norm_y_o,
  output logic [31:0] norm_z_o,
  output logic [31:0] norm_w_o,
  output logic [31:0] vec_length_o,
  output logic        was_zero_o
);

  localparam int CW   = COMP_WIDTH;
  localparam int DW   = COMP_WIDTH+FRAC_BITS;
  localparam int NSQ  = COMP_WIDTH+1;
  localparam int RADW = 2*COMP_WIDTH+2;
  localparam int RW   = COMP_WIDTH+4;
  localparam int RT   = COMP_WIDTH+1;
  localparam int L    = vn4_pkg::LANES;
  localparam int DRW  = vn4_pkg::DRW;
  localparam logic [DW-1:0] LIM_NEG = DW'(1) << (CW-1);
  localparam logic [DW-1:0] LIM_POS = LIM_NEG - DW'(1);

  typedef logic [L-1:0][CW-1:0] raw_t;

  logic en;
  logic [vn4_pkg::THR_W-1:0] thr_q;

  // threshold register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= vn4_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= zero_threshold_i;
    end
  end

  // input stage: keep the low bits and split off the signs
  raw_t raw_in;
  logic [L-1:0] neg_in;
  assign raw_in[0] = comp_x_i[CW-1:0];
  assign raw_in[1] = comp_y_i[CW-1:0];
  assign raw_in[2] = comp_z_i[CW-1:0];
  assign raw_in[3] = comp_w_i[CW-1:0];
  always_comb begin
    for (int i = 0; i < L; i++) begin
      neg_in[i] = raw_in[i][CW-1];
    end
  end

  vn4_pkg::vn4_ctl_t s0_ctl_q, s1_ctl_q, s2_ctl_q, s3_ctl_q;
  raw_t s0_raw_q, s1_raw_q, s2_raw_q, s3_raw_q;
  logic [L-1:0][CW-1:0]   mag_d;
  logic [L-1:0][2*CW-1:0] s1_sq_q;
  logic [1:0][2*CW:0]     s2_sum_q;
  logic [RADW-1:0]        s3_sum_q;

  // magnitudes of the registered components
  always_comb begin
    for (int i = 0; i < L; i++) begin
      mag_d[i] = s0_ctl_q.neg[i] ? (CW'(0) - s0_raw_q[i]) : s0_raw_q[i];
    end
  end

  // front stages control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else if (en) begin
      s0_ctl_q <= '{vld: in_valid_i, is_zero: 1'b0, neg: neg_in};
      s1_ctl_q <= s0_ctl_q;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // front stages payload: square, then a two-level adder tree
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_raw_q <= raw_in;
      s1_raw_q <= s0_raw_q;
      s2_raw_q <= s1_raw_q;
      s3_raw_q <= s2_raw_q;
      for (int i = 0; i < L; i++) begin
        s1_sq_q[i] <= mag_d[i] * mag_d[i];
      end
      s2_sum_q[0] <= (2*CW+1)'(s1_sq_q[0]) + (2*CW+1)'(s1_sq_q[1]);
      s2_sum_q[1] <= (2*CW+1)'(s1_sq_q[2]) + (2*CW+1)'(s1_sq_q[3]);
      s3_sum_q    <= RADW'(s2_sum_q[0]) + RADW'(s2_sum_q[1]);
    end
  end

  // square-root chain
  vn4_pkg::vn4_ctl_t sq_ctl [NSQ+1];
  logic [RADW-1:0]   sq_rad [NSQ+1];
  logic [RW-1:0]     sq_rem [NSQ+1];
  logic [RT-1:0]     sq_root[NSQ+1];
  raw_t              sq_raw [NSQ+1];

  assign sq_ctl[0]  = s3_ctl_q;
  assign sq_rad[0]  = s3_sum_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_raw[0]  = s3_raw_q;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    vn4_sqrt_cell #(.COMP_WIDTH(CW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[g]),
      .rad_i  (sq_rad[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .raw_i  (sq_raw[g]),
      .ctl_o  (sq_ctl[g+1]),
      .rad_o  (sq_rad[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .raw_o  (sq_raw[g+1])
    );
  end

  // length saturation and zero check
  logic [32:0] root_ext;
  logic [31:0] len_d;
  logic        zero_d;
  assign root_ext = 33'(sq_root[NSQ]);
  assign len_d    = root_ext[32] ? 32'hFFFF_FFFF : root_ext[31:0];
  assign zero_d   = (len_d == 32'd0) || (len_d < 32'(thr_q));

  vn4_pkg::vn4_ctl_t s4_ctl_q;
  logic [31:0] s4_len_q;
  raw_t        s4_raw_q;
  logic [L-1:0][CW-1:0] s4_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctl_q <= '0;
    end else if (en) begin
      s4_ctl_q <= '{vld: sq_ctl[NSQ].vld, is_zero: zero_d, neg: sq_ctl[NSQ].neg};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_len_q <= len_d;
      s4_raw_q <= sq_raw[NSQ];
    end
  end

  always_comb begin
    for (int i = 0; i < L; i++) begin
      s4_mag[i] = s4_ctl_q.neg[i] ? (CW'(0) - s4_raw_q[i]) : s4_raw_q[i];
    end
  end

  // divider chain
  vn4_pkg::vn4_ctl_t   dv_ctl[DW+1];
  logic [31:0]         dv_len[DW+1];
  raw_t                dv_raw[DW+1];
  logic [L-1:0][DRW-1:0] dv_rem[DW+1];
  logic [L-1:0][DW-1:0]  dv_dvd[DW+1];
  logic [L-1:0][DW-1:0]  dv_quo[DW+1];

  assign dv_ctl[0] = s4_ctl_q;
  assign dv_len[0] = s4_len_q;
  assign dv_raw[0] = s4_raw_q;
  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;
  always_comb begin
    for (int i = 0; i < L; i++) begin
      dv_dvd[0][i] = DW'(s4_mag[i]) << FRAC_BITS;
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_div
    vn4_div_cell #(.COMP_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dv_ctl[g]),
      .len_i  (dv_len[g]),
      .raw_i  (dv_raw[g]),
      .rem_i  (dv_rem[g]),
      .dvd_i  (dv_dvd[g]),
      .quo_i  (dv_quo[g]),
      .ctl_o  (dv_ctl[g+1]),
      .len_o  (dv_len[g+1]),
      .raw_o  (dv_raw[g+1]),
      .rem_o  (dv_rem[g+1]),
      .dvd_o  (dv_dvd[g+1]),
      .quo_o  (dv_quo[g+1])
    );
  end

  // pack the quotients with sign and saturation, or pass through
  vn4_pkg::vn4_res_t res_d;
  logic [DW-1:0] qsat;
  always_comb begin
    qsat = '0;
    res_d.len      = dv_len[DW];
    res_d.was_zero = dv_ctl[DW].is_zero;
    for (int i = 0; i < L; i++) begin
      if (dv_ctl[DW].is_zero) begin
        res_d.norm[i] = 32'(signed'(dv_raw[DW][i]));
      end else if (dv_ctl[DW].neg[i]) begin
        qsat          = (dv_quo[DW][i] > LIM_NEG) ? LIM_NEG : dv_quo[DW][i];
        res_d.norm[i] = 32'd0 - 32'(qsat);
      end else begin
        qsat          = (dv_quo[DW][i] > LIM_POS) ? LIM_POS : dv_quo[DW][i];
        res_d.norm[i] = 32'(qsat);
      end
    end
  end

  // output register with a skid entry
  vn4_pkg::vn4_res_t out_q, skid_q;
  logic out_vld_q, skid_vld_q;

  assign en = !skid_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_ready_i || !out_vld_q) begin
      out_vld_q  <= skid_vld_q || dv_ctl[DW].vld;
      skid_vld_q <= 1'b0;
    end else if (dv_ctl[DW].vld && en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (en) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign norm_x_o     = out_q.norm[0];
  assign norm_y_o     = out_q.norm[1];
  assign norm_z_o     = out_q.norm[2];
  assign norm_w_o     = out_q.norm[3];
  assign vec_length_o = out_q.len;
  assign was_zero_o   = out_q.was_zero;

endmodule

// ===== design/vn4_check.sv =====
// ----------------------------------------------------------------------------
// vn4_check
// port-level checks for the vector normaliser, bound to the top level
// ----------------------------------------------------------------------------
module vn4_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [15:0] zero_threshold_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] comp_x_i,
  input logic [31:0] comp_y_i,
  input logic [31:0] comp_z_i,
  input logic [31:0] comp_w_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] norm_x_o,
  input logic [31:0] norm_y_o,
  input logic [31:0] norm_z_o,
  input logic [31:0] norm_w_o,
  input logic [31:0] vec_length_o,
  input logic        was_zero_o
);

  // nothing comes out in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result beat during reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(norm_x_o)
      && $stable(vec_length_o) && $stable(was_zero_o))
    else $error("result beat changed while stalled");

  // input back-pressure only with a result waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a normalised result always has a non-zero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_zero_o |-> vec_length_o != 32'd0)
    else $error("normalised beat with zero length");

  // a zero length means a zero vector came through
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vec_length_o == 32'd0 |-> was_zero_o && norm_x_o == 32'd0
      && norm_y_o == 32'd0 && norm_z_o == 32'd0 && norm_w_o == 32'd0)
    else $error("zero length with non-zero components");

endmodule

bind vector4_normalize vn4_check u_vn4_check (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the four-component vector normaliser
// ----------------------------------------------------------------------------
// Drives vectors over the input channel and predicts each result from its own
// model of the length, the zero check and the division. Every output beat is
// compared field by field with the oldest prediction. The test tasks cover
// edge vectors, threshold settings, random vectors under several idle patterns
// and a long output stall that fills the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 16;
  localparam int CYC_MAX  = 600000;
  localparam int DRAIN    = 120;

  typedef logic [vn4_pkg::LANES-1:0][31:0] vec_t;

  typedef struct packed {
    vec_t        norm;
    logic [31:0] len;
    logic        was_zero;
  } norm_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] zero_threshold_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] comp_x_i = '0, comp_y_i = '0, comp_z_i = '0, comp_w_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] norm_x_o, norm_y_o, norm_z_o, norm_w_o, vec_length_o;
  logic        was_zero_o;

  norm_res_t   pending_q[$];
  logic [15:0] threshold = vn4_pkg::THR_RESET;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          errors = 0;
  int          cycles = 0;
  bit          stall_req = 0;
  int          stall_left = 0;

  vector4_normalize #(.FRAC_BITS(FRAC), .COMP_WIDTH(32)) dut (.*);

  // clock
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_MAX) begin
      $display("FAIL vector4_normalize");
      $finish;
    end
  end

  // floor square root of a 64-bit sum
  function automatic logic [31:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // expected normalised vector, length and zero flag
  function automatic norm_res_t normalise(input vec_t c, input logic [15:0] thr);
    norm_res_t   r;
    logic [64:0] sumsq;
    logic [31:0] mag[vn4_pkg::LANES];
    logic [63:0] q;
    logic [31:0] len;
    sumsq = '0;
    for (int i = 0; i < vn4_pkg::LANES; i++) begin
      mag[i] = c[i][31] ? (32'd0 - c[i]) : c[i];
      sumsq = sumsq + 65'(64'(mag[i]) * 64'(mag[i]));
    end
    len = sumsq[64] ? 32'hFFFF_FFFF : root64(sumsq[63:0]);
    r.len = len;
    r.was_zero = (len == 0) || (len < 32'(thr));
    for (int i = 0; i < vn4_pkg::LANES; i++) begin
      if (r.was_zero) begin
        r.norm[i] = c[i];
      end else begin
        q = (64'(mag[i]) << FRAC) / 64'(len);
        if (c[i][31]) begin
          if (q > 64'h8000_0000) q = 64'h8000_0000;
          r.norm[i] = 32'd0 - q[31:0];
        end else begin
          if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
          r.norm[i] = q[31:0];
        end
      end
    end
    return r;
  endfunction

  // output ready, random idling or a long hold-off
  always @(posedge clk_i) begin
    if (stall_req && stall_left == 0) begin
      stall_left <= 400;
      stall_req <= 0;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    norm_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result beat with no vector outstanding");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (norm_x_o !== e.norm[0]) begin
          $error("norm_x exp %h got %h", e.norm[0], norm_x_o); errors++;
        end
        if (norm_y_o !== e.norm[1]) begin
          $error("norm_y exp %h got %h", e.norm[1], norm_y_o); errors++;
        end
        if (norm_z_o !== e.norm[2]) begin
          $error("norm_z exp %h got %h", e.norm[2], norm_z_o); errors++;
        end
        if (norm_w_o !== e.norm[3]) begin
          $error("norm_w exp %h got %h", e.norm[3], norm_w_o); errors++;
        end
        if (vec_length_o !== e.len) begin
          $error("vec_length exp %h got %h", e.len, vec_length_o); errors++;
        end
        if (was_zero_o !== e.was_zero) begin
          $error("was_zero exp %b got %b", e.was_zero, was_zero_o); errors++;
        end
      end
    end
  end

  // send one vector beat, valid stays up if the next beat follows at once
  task automatic send_vector(input vec_t c);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    comp_x_i <= c[0];
    comp_y_i <= c[1];
    comp_z_i <= c[2];
    comp_w_i <= c[3];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(normalise(c, threshold));
  endtask

  // wait for the block to empty, then write the threshold
  task automatic write_threshold(input logic [15:0] thr);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    zero_threshold_i <= thr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    threshold = thr;
  endtask

  // random component, magnitude spread over all scales
  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = 32'($signed($urandom) >>> $urandom_range(31));
      2: v = $urandom_range(131072) - 32'd65536;
      default: v = $urandom >> $urandom_range(31);
    endcase
    return v;
  endfunction

  function automatic vec_t rand_vec();
    vec_t c;
    for (int i = 0; i < vn4_pkg::LANES; i++) c[i] = rand_comp();
    if ($urandom_range(7) == 0) c[$urandom_range(3)] = '0;
    return c;
  endfunction

  // edge vectors at the reset threshold and at threshold zero
  task automatic test_edges();
    send_vector('{32'd0, 32'd0, 32'd0, 32'd0});
    send_vector('{32'd0, 32'd0, 32'd0, 32'd1});
    send_vector('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_vector('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vector('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_vector('{32'h8000_0000, 32'd0, 32'd0, 32'd0});
    send_vector('{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0});
    send_vector('{32'd0, 32'd0, 32'd65536, 32'd0});
    send_vector('{32'hFFFF_0000, 32'd0, 32'd0, 32'd0});
    send_vector('{32'd65536, 32'd65536, 32'd65536, 32'd65536});
    send_vector('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0001});
    send_vector('{32'd3, 32'hFFFF_FFFC, 32'd0, 32'd0});
    write_threshold(16'd0);
    send_vector('{32'd0, 32'd0, 32'd0, 32'd0});
    send_vector('{32'd1, 32'd0, 32'd0, 32'd0});
    send_vector('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
  endtask

  // the maximum threshold with vectors around it, then random thresholds
  task automatic test_threshold();
    logic [15:0] thr;
    write_threshold(16'hFFFF);
    send_vector('{32'd65535, 32'd0, 32'd0, 32'd0});
    send_vector('{32'd65534, 32'd0, 32'd0, 32'd0});
    send_vector('{32'hFFFF_0001, 32'd0, 32'd0, 32'd0});
    send_vector('{32'd0, 32'd0, 32'd0, 32'h8000_0000});
    for (int i = 0; i < 20; i++) begin
      send_vector('{$urandom_range(70000) - 32'd35000, $urandom_range(70000) - 32'd35000,
                    $urandom_range(70000) - 32'd35000, $urandom_range(70000) - 32'd35000});
    end
    for (int k = 0; k < 3; k++) begin
      thr = 16'($urandom);
      write_threshold(thr);
      send_vector('{32'(thr), 32'd0, 32'd0, 32'd0});
      send_vector('{32'(thr) - 32'd1, 32'd0, 32'd0, 32'd0});
      for (int i = 0; i < 10; i++) send_vector(rand_vec());
    end
  endtask

  // random vectors under three idle patterns
  task automatic test_random();
    int s_pat[3] = '{16, 53, 0};
    int r_pat[3] = '{53, 16, 0};
    logic [15:0] thr_pat[3] = '{16'd1, 16'd300, 16'd0};
    for (int p = 0; p < 3; p++) begin
      write_threshold(thr_pat[p]);
      send_idle = s_pat[p];
      recv_idle = r_pat[p];
      for (int i = 0; i < 150; i++) send_vector(rand_vec());
    end
  endtask

  // output held off while input keeps coming, block must stall its input
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 10;
    stall_req = 1;
    for (int i = 0; i < 150; i++) send_vector(rand_vec());
    recv_idle = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_threshold();
    test_random();
    test_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS vector4_normalize");
    end else begin
      $display("FAIL vector4_normalize");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vn4_pkg.sv
design/vn4_sqrt_cell.sv
design/vn4_div_cell.sv
design/vector4_normalize.sv
design/vn4_check.sv
test/testbench.sv
